// File: rtl/core/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIV_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_TEMP      = 3'd0,
    REG_CAL_PRESS_A   = 3'd1,
    REG_CAL_PRESS_B   = 3'd2,
    REG_CAL_PRESS_HUM = 3'd3,
    REG_CAL_HUM_B     = 3'd4
  } cfg_reg_e;

  // results that ride alongside the divider
  typedef struct packed {
    logic signed [20:0] temperature_centi;
    logic [16:0]        humidity_q22_10;
  } side_t;

  localparam logic signed [33:0] T_FINE_OFS = 34'sd128000;
  localparam logic [31:0]        HUM_T_OFS  = 32'd76800;
  localparam logic [31:0]        HUM_MAX    = 32'd419430400;

endpackage

// File: rtl/core/esc_sdiv.sv
`timescale 1ns / 1ps
module esc_sdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [esc_pkg::DIV_W-1:0]  num_i,
  input  logic [esc_pkg::DIV_W-1:0]  den_i,
  input  esc_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [esc_pkg::DIV_W-1:0]  quot_o,
  output logic                       zero_o,
  output esc_pkg::side_t             side_o
);
  import esc_pkg::*;

  logic [DIV_W-1:0] rem_q  [0:DIV_W];
  logic [DIV_W-1:0] nq_q   [0:DIV_W];
  logic [DIV_W-1:0] ad_q   [0:DIV_W];
  logic             neg_q  [0:DIV_W];
  logic             zero_q [0:DIV_W];
  side_t            side_q [0:DIV_W];
  logic [DIV_W:0]   vld_q;

  logic [DIV_W-1:0] an_d;
  logic [DIV_W-1:0] ad_d;

  assign an_d = num_i[DIV_W-1] ? (~num_i + 1'b1) : num_i;
  assign ad_d = den_i[DIV_W-1] ? (~den_i + 1'b1) : den_i;

  // sign and magnitude stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      nq_q[0]   <= an_d;
      ad_q[0]   <= ad_d;
      neg_q[0]  <= num_i[DIV_W-1] ^ den_i[DIV_W-1];
      zero_q[0] <= (den_i == '0);
      side_q[0] <= side_i;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DIV_W; k++) begin : g_step
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;

    assign rem_sh = {rem_q[k-1], nq_q[k-1][DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, ad_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= diff[DIV_W+1] ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
        nq_q[k]   <= {nq_q[k-1][DIV_W-2:0], ~diff[DIV_W+1]};
        ad_q[k]   <= ad_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic             valid_q;
  logic [DIV_W-1:0] quot_q;
  logic             zero_out_q;
  side_t            side_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vld_q[DIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q     <= neg_q[DIV_W] ? (~nq_q[DIV_W] + 1'b1) : nq_q[DIV_W];
      zero_out_q <= zero_q[DIV_W];
      side_out_q <= side_q[DIV_W];
    end
  end

  assign valid_o = valid_q;
  assign quot_o  = quot_q;
  assign zero_o  = zero_out_q;
  assign side_o  = side_out_q;

endmodule

// File: rtl/core/env_sensor_compensation_top.sv
`timescale 1ns / 1ps
// channel   | valid / stall          | payload
// input     | in_valid_i / in_stall_o   | raw_temperature_i, raw_pressure_i, raw_humidity_i
// output    | out_valid_o / out_stall_i | temperature_centi_o, pressure_q24_8_o,
//           |                           | humidity_q22_10_o, pressure_divisor_zero_o
// config    | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// one transaction per cycle unless stalled; the signed divider has 64 quotient stages
// the whole pipeline advances together; it holds only while the output register is
// full and stalled, so in_stall_o follows out_stall_i in that case
// reset clears valid bits and calibration registers
module env_sensor_compensation_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [19:0]                      raw_temperature_i,
  input  logic [19:0]                      raw_pressure_i,
  input  logic [15:0]                      raw_humidity_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [20:0]               temperature_centi_o,
  output logic [31:0]                      pressure_q24_8_o,
  output logic [16:0]                      humidity_q22_10_o,
  output logic                             pressure_divisor_zero_o
);
  import esc_pkg::*;

  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [47:0] cal_press_hum_q;
  logic [31:0] cal_hum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q      <= '0;
      cal_press_a_q   <= '0;
      cal_press_b_q   <= '0;
      cal_press_hum_q <= '0;
      cal_hum_b_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CAL_TEMP:      cal_temp_q      <= cfg_data_i[47:0];
        REG_CAL_PRESS_A:   cal_press_a_q   <= cfg_data_i;
        REG_CAL_PRESS_B:   cal_press_b_q   <= cfg_data_i;
        REG_CAL_PRESS_HUM: cal_press_hum_q <= cfg_data_i[47:0];
        REG_CAL_HUM_B:     cal_hum_b_q     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = cal_temp_q[15:0];
  assign t2 = cal_temp_q[31:16];
  assign t3 = cal_temp_q[47:32];
  assign p1 = cal_press_a_q[15:0];
  assign p2 = cal_press_a_q[31:16];
  assign p3 = cal_press_a_q[47:32];
  assign p4 = cal_press_a_q[63:48];
  assign p5 = cal_press_b_q[15:0];
  assign p6 = cal_press_b_q[31:16];
  assign p7 = cal_press_b_q[47:32];
  assign p8 = cal_press_b_q[63:48];
  assign p9 = cal_press_hum_q[15:0];
  assign h1 = cal_press_hum_q[23:16];
  assign h2 = cal_press_hum_q[39:24];
  assign h3 = cal_press_hum_q[47:40];
  assign h4 = cal_hum_b_q[11:0];
  assign h5 = cal_hum_b_q[23:12];
  assign h6 = cal_hum_b_q[31:24];

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic [13:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[12:1], in_valid_i};
    end
  end

  // temperature front end
  logic [31:0] s1_a_q, s1_b_q, s2_ma_q, s2_bb_q, s3_v1_q, s3_m3_q, s4_tf_q;
  logic [19:0] s1_pr_q, s2_pr_q, s3_pr_q, s4_pr_q, s5_pr_q, s6_pr_q, s7_pr_q, s8_pr_q;
  logic [15:0] s1_hr_q, s2_hr_q, s3_hr_q, s4_hr_q, s5_hr_q, s6_hr_q;
  logic signed [20:0] s5_t_q, s6_t_q, s7_t_q, s8_t_q, s9_t_q, s10_t_q, s11_t_q,
                      s12_t_q, s13_t_q;
  logic signed [33:0] s5_q1a_q;
  logic [31:0]        s5_hx_q;

  logic [31:0] tmp5;
  logic [31:0] tf5;

  assign tf5  = s4_tf_q;
  assign tmp5 = (tf5 << 2) + tf5 + 32'd128;

  // pressure and humidity middle
  logic signed [67:0] sq_full;
  logic signed [49:0] m5_d, m2_d;
  logic [63:0]        s6_sq_q;
  logic signed [49:0] s6_m5_q, s6_m2_q;
  logic [31:0]        s6_hm5_q, s6_xh6_q, s6_xh3_q;

  logic signed [79:0] sq6_full, sq3_full;
  logic [31:0]        p1pre;
  logic [63:0]        s7_sq6_q, s7_sq3_q;
  logic signed [49:0] s7_m5_q, s7_m2_q;
  logic [31:0]        s7_part1_q, s7_f1_q, s7_f2_q;

  logic [63:0] s8_q2_q, s8_q1b_q;
  logic [31:0] s8_part1_q, s8_inner_q;

  logic [79:0] dprod_full;
  logic [63:0] s9_dprod_q, s9_num_q;
  logic [31:0] s9_part1_q, s9_g_q;

  logic [76:0] numm_full;
  logic [63:0] s10_den_q, s10_num_q, s11_den_q, s11_num_q, s12_den_q, s12_num_q,
               s13_den_q, s13_num_q;
  logic [31:0] s10_part1_q, s10_part2_q;

  logic [31:0] s11_hx_q, s12_hx_q, s12_ss_q, s13_hx_q, s13_c1_q;
  logic [31:0] s12_s;

  assign sq_full  = s5_q1a_q * s5_q1a_q;
  assign m5_d     = s5_q1a_q * p5;
  assign m2_d     = s5_q1a_q * p2;
  assign sq6_full = $signed(s6_sq_q) * p6;
  assign sq3_full = $signed(s6_sq_q) * p3;
  assign p1pre    = (32'(s6_hr_q) << 14) - (32'(h4) << 20) - s6_hm5_q + 32'd16384;
  assign dprod_full = (64'h0000_8000_0000_0000 + s8_q1b_q) * p1;
  assign numm_full  = s9_num_q * 13'd3125;
  assign s12_s      = 32'($signed(s11_hx_q) >>> 15);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q  <= 32'(raw_temperature_i >> 3) - (32'(t1) << 1);
      s1_b_q  <= 32'(raw_temperature_i >> 4) - 32'(t1);
      s1_pr_q <= raw_pressure_i;
      s1_hr_q <= raw_humidity_i;

      s2_ma_q <= s1_a_q * 32'(t2);
      s2_bb_q <= s1_b_q * s1_b_q;
      s2_pr_q <= s1_pr_q;
      s2_hr_q <= s1_hr_q;

      s3_v1_q <= 32'($signed(s2_ma_q) >>> 11);
      s3_m3_q <= 32'($signed(s2_bb_q) >>> 12) * 32'(t3);
      s3_pr_q <= s2_pr_q;
      s3_hr_q <= s2_hr_q;

      s4_tf_q <= s3_v1_q + 32'($signed(s3_m3_q) >>> 14);
      s4_pr_q <= s3_pr_q;
      s4_hr_q <= s3_hr_q;

      s5_t_q   <= tmp5[28:8];
      s5_q1a_q <= 34'($signed(s4_tf_q)) - T_FINE_OFS;
      s5_hx_q  <= s4_tf_q - HUM_T_OFS;
      s5_pr_q  <= s4_pr_q;
      s5_hr_q  <= s4_hr_q;

      s6_sq_q  <= sq_full[63:0];
      s6_m5_q  <= m5_d;
      s6_m2_q  <= m2_d;
      s6_hm5_q <= 32'(h5) * s5_hx_q;
      s6_xh6_q <= s5_hx_q * 32'(h6);
      s6_xh3_q <= s5_hx_q * 32'(h3);
      s6_t_q   <= s5_t_q;
      s6_pr_q  <= s5_pr_q;
      s6_hr_q  <= s5_hr_q;

      s7_sq6_q   <= sq6_full[63:0];
      s7_sq3_q   <= sq3_full[63:0];
      s7_m5_q    <= s6_m5_q;
      s7_m2_q    <= s6_m2_q;
      s7_part1_q <= 32'($signed(p1pre) >>> 15);
      s7_f1_q    <= 32'($signed(s6_xh6_q) >>> 10);
      s7_f2_q    <= 32'($signed(s6_xh3_q) >>> 11) + 32'd32768;
      s7_t_q     <= s6_t_q;
      s7_pr_q    <= s6_pr_q;

      s8_q2_q    <= s7_sq6_q + (64'(s7_m5_q) << 17) + (64'(p4) << 35);
      s8_q1b_q   <= 64'($signed(s7_sq3_q) >>> 8) + (64'(s7_m2_q) << 12);
      s8_inner_q <= s7_f1_q * s7_f2_q;
      s8_part1_q <= s7_part1_q;
      s8_t_q     <= s7_t_q;
      s8_pr_q    <= s7_pr_q;

      s9_dprod_q <= dprod_full[63:0];
      s9_num_q   <= ((64'd1048576 - 64'(s8_pr_q)) << 31) - s8_q2_q;
      s9_g_q     <= (32'($signed(s8_inner_q) >>> 10) + 32'd2097152) * 32'(h2);
      s9_part1_q <= s8_part1_q;
      s9_t_q     <= s8_t_q;

      s10_den_q   <= 64'($signed(s9_dprod_q) >>> 33);
      s10_num_q   <= numm_full[63:0];
      s10_part2_q <= 32'($signed(s9_g_q + 32'd8192) >>> 14);
      s10_part1_q <= s9_part1_q;
      s10_t_q     <= s9_t_q;

      s11_hx_q  <= s10_part1_q * s10_part2_q;
      s11_den_q <= s10_den_q;
      s11_num_q <= s10_num_q;
      s11_t_q   <= s10_t_q;

      s12_ss_q  <= s12_s * s12_s;
      s12_hx_q  <= s11_hx_q;
      s12_den_q <= s11_den_q;
      s12_num_q <= s11_num_q;
      s12_t_q   <= s11_t_q;

      s13_c1_q  <= 32'($signed(s12_ss_q) >>> 7) * 32'(h1);
      s13_hx_q  <= s12_hx_q;
      s13_den_q <= s12_den_q;
      s13_num_q <= s12_num_q;
      s13_t_q   <= s12_t_q;
    end
  end

  // humidity finish and clamp
  logic [31:0] hum_x;
  logic [31:0] hum_c;
  side_t       side_in;

  assign hum_x = s13_hx_q - 32'($signed(s13_c1_q) >>> 4);

  always_comb begin
    if (hum_x[31]) begin
      hum_c = '0;
    end else if (hum_x > HUM_MAX) begin
      hum_c = HUM_MAX;
    end else begin
      hum_c = hum_x;
    end
    side_in.temperature_centi = s13_t_q;
    side_in.humidity_q22_10   = hum_c[28:12];
  end

  logic             dv_valid;
  logic [DIV_W-1:0] dv_quot;
  logic             dv_zero;
  side_t            dv_side;

  esc_sdiv u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[13]),
    .num_i   (s13_num_q),
    .den_i   (s13_den_q),
    .side_i  (side_in),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .zero_o  (dv_zero),
    .side_o  (dv_side)
  );

  // pressure back end
  logic [3:1]         pv_q;
  logic signed [63:0] a13;
  logic signed [79:0] m9_full, m8_full;
  logic [63:0] b1_pr_q, b1_a13_q, b1_m9_q, b1_m8_q;
  logic [63:0] b2_pr_q, b2_ll_q, b2_q2b_q;
  logic [31:0] b2_lh_q, b2_hl_q;
  logic [63:0] b3_pr_q, b3_q1c_q, b3_q2b_q;
  logic [63:0] prod3;
  logic [63:0] fin4;
  logic        b1_zero_q, b2_zero_q, b3_zero_q;
  side_t       b1_side_q, b2_side_q, b3_side_q;

  assign a13     = $signed(dv_quot) >>> 13;
  assign m9_full = a13 * p9;
  assign m8_full = $signed(dv_quot) * p8;
  assign prod3   = b2_ll_q + {b2_lh_q + b2_hl_q, 32'd0};
  assign fin4    = 64'($signed(b3_pr_q + b3_q1c_q + b3_q2b_q) >>> 8) + (64'(p7) << 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pv_q        <= {pv_q[2:1], dv_valid};
      out_valid_q <= pv_q[3];
    end
  end

  logic signed [20:0] temp_out_q;
  logic [31:0]        press_out_q;
  logic [16:0]        hum_out_q;
  logic               zero_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_pr_q   <= dv_quot;
      b1_a13_q  <= a13;
      b1_m9_q   <= m9_full[63:0];
      b1_m8_q   <= m8_full[63:0];
      b1_zero_q <= dv_zero;
      b1_side_q <= dv_side;

      b2_ll_q   <= b1_m9_q[31:0] * b1_a13_q[31:0];
      b2_lh_q   <= b1_m9_q[31:0] * b1_a13_q[63:32];
      b2_hl_q   <= b1_m9_q[63:32] * b1_a13_q[31:0];
      b2_q2b_q  <= 64'($signed(b1_m8_q) >>> 19);
      b2_pr_q   <= b1_pr_q;
      b2_zero_q <= b1_zero_q;
      b2_side_q <= b1_side_q;

      b3_q1c_q  <= 64'($signed(prod3) >>> 25);
      b3_q2b_q  <= b2_q2b_q;
      b3_pr_q   <= b2_pr_q;
      b3_zero_q <= b2_zero_q;
      b3_side_q <= b2_side_q;

      temp_out_q  <= b3_side_q.temperature_centi;
      hum_out_q   <= b3_side_q.humidity_q22_10;
      press_out_q <= b3_zero_q ? 32'd0 : fin4[31:0];
      zero_out_q  <= b3_zero_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign temperature_centi_o     = temp_out_q;
  assign pressure_q24_8_o        = press_out_q;
  assign humidity_q22_10_o       = hum_out_q;
  assign pressure_divisor_zero_o = zero_out_q;

endmodule

// File: rtl/core/esc_checker.sv
`timescale 1ns / 1ps
module esc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [20:0]               temperature_centi_o,
  input logic [31:0]                      pressure_q24_8_o,
  input logic [16:0]                      humidity_q22_10_o,
  input logic                             pressure_divisor_zero_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pressure_q24_8_o) &&
      $stable(temperature_centi_o) && $stable(humidity_q22_10_o))
    else $error("stalled output payload changed");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with free output");

  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_divisor_zero_o |-> pressure_q24_8_o == 32'd0)
    else $error("pressure nonzero with zero divisor");

  a_hum_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_q22_10_o <= 17'd102400)
    else $error("humidity above clamp");

endmodule

bind env_sensor_compensation_top esc_checker u_esc_checker (.*);

// File: test/env_sensor_compensation_top_test.sv
`timescale 1ns / 1ps
module env_sensor_compensation_top_test;
  import esc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam int HOLD_CYCLES = 400;
  localparam int LATENCY = 83;

  typedef struct {
    logic signed [20:0] temp;
    logic [31:0]        press;
    logic [16:0]        hum;
    logic               div_zero;
  } reading_t;

  class compensation_board;
    logic [63:0] cal[5];
    reading_t    expected_q[$];
    int          n_errors;
    int          n_checked;

    function void set_cal(cfg_reg_e idx, logic [63:0] val);
      cal[idx] = val;
    endfunction

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
      logic signed [63:0] s;
      s = x;
      return s >>> n;
    endfunction

    function automatic logic [63:0] sdiv64(logic [63:0] n, logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q = an / ad;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function void note_raw(logic [19:0] t_raw, logic [19:0] p_raw, logic [15:0] h_raw);
      logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6, tr, hr;
      logic [31:0] a, b, v1, v2, tf, x, part1, part2, inner, corr;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, pr, tf64;
      reading_t r;
      t1 = {16'b0, cal[0][15:0]};
      t2 = sx16(cal[0][31:16]);
      t3 = sx16(cal[0][47:32]);
      p1 = {48'b0, cal[1][15:0]};
      p2 = sx16(cal[1][31:16]);
      p3 = sx16(cal[1][47:32]);
      p4 = sx16(cal[1][63:48]);
      p5 = sx16(cal[2][15:0]);
      p6 = sx16(cal[2][31:16]);
      p7 = sx16(cal[2][47:32]);
      p8 = sx16(cal[2][63:48]);
      p9 = sx16(cal[3][15:0]);
      h1 = {24'b0, cal[3][23:16]};
      h2 = sx16(cal[3][39:24]);
      h3 = {24'b0, cal[3][47:40]};
      h4 = {{20{cal[4][11]}}, cal[4][11:0]};
      h5 = {{20{cal[4][23]}}, cal[4][23:12]};
      h6 = {{24{cal[4][31]}}, cal[4][31:24]};
      tr = {12'b0, t_raw};
      hr = {16'b0, h_raw};

      // fine temperature
      a = (tr >> 3) - (t1 << 1);
      v1 = asr32(a * t2, 11);
      b = (tr >> 4) - t1;
      v2 = asr32(asr32(b * b, 12) * t3, 14);
      tf = v1 + v2;
      x = tf * 32'd5 + 32'd128;
      x = asr32(x, 8);
      r.temp = x[20:0];

      // pressure
      tf64 = {{32{tf[31]}}, tf};
      q1 = tf64 - 64'd128000;
      q2 = q1 * q1 * p6;
      q2 = q2 + ((q1 * p5) << 17);
      q2 = q2 + (p4 << 35);
      q1 = asr64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
      q1 = asr64(((64'd1 << 47) + q1) * p1, 33);
      if (q1 == 64'd0) begin
        r.press = 32'd0;
        r.div_zero = 1'b1;
      end else begin
        pr = 64'd1048576 - {44'b0, p_raw};
        pr = sdiv64(((pr << 31) - q2) * 64'd3125, q1);
        q1 = asr64(p9 * asr64(pr, 13) * asr64(pr, 13), 25);
        q2 = asr64(p8 * pr, 19);
        pr = asr64(pr + q1 + q2, 8) + (p7 << 4);
        r.press = pr[31:0];
        r.div_zero = 1'b0;
      end

      // humidity
      x = tf - 32'd76800;
      part1 = asr32((hr << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
      inner = asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768);
      part2 = asr32((asr32(inner, 10) + 32'd2097152) * h2 + 32'd8192, 14);
      x = part1 * part2;
      corr = asr32(asr32(asr32(x, 15) * asr32(x, 15), 7) * h1, 4);
      x = x - corr;
      if (x[31]) x = 32'd0;
      else if (x > 32'd419430400) x = 32'd419430400;
      x = x >> 12;
      r.hum = x[16:0];
      expected_q.push_back(r);
    endfunction

    function void check_reading(logic signed [20:0] t, logic [31:0] p, logic [16:0] h,
                                logic dz);
      reading_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      if (t !== e.temp) begin
        $error("temperature_centi expected %0d got %0d", e.temp, t);
        n_errors++;
      end
      if (p !== e.press) begin
        $error("pressure_q24_8 expected %h got %h", e.press, p);
        n_errors++;
      end
      if (h !== e.hum) begin
        $error("humidity_q22_10 expected %0d got %0d", e.hum, h);
        n_errors++;
      end
      if (dz !== e.div_zero) begin
        $error("pressure_divisor_zero expected %b got %b", e.div_zero, dz);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [19:0] raw_temperature_i, raw_pressure_i;
  logic [15:0] raw_humidity_i;
  logic out_valid_o, out_stall_i;
  logic signed [20:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;
  logic [16:0] humidity_q22_10_o;
  logic pressure_divisor_zero_o;

  compensation_board board = new();
  bit idle_on;
  bit hold_req;
  int hold_left;
  int n_sent;
  int n_cal_sets;

  env_sensor_compensation_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  // result side
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_reading(temperature_centi_o, pressure_q24_8_o, humidity_q22_10_o,
                            pressure_divisor_zero_o);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 33);
      end
    end
  end

  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_CAL_TEMP:      board.set_cal(REG_CAL_TEMP, val & 64'hFFFF_FFFF_FFFF);
      REG_CAL_PRESS_A:   board.set_cal(REG_CAL_PRESS_A, val);
      REG_CAL_PRESS_B:   board.set_cal(REG_CAL_PRESS_B, val);
      REG_CAL_PRESS_HUM: board.set_cal(REG_CAL_PRESS_HUM, val & 64'hFFFF_FFFF_FFFF);
      REG_CAL_HUM_B:     board.set_cal(REG_CAL_HUM_B, val & 64'hFFFF_FFFF);
      default: ;
    endcase
  endtask

  task automatic load_cal_set(logic [63:0] ct, logic [63:0] pa, logic [63:0] pb,
                              logic [63:0] ph, logic [63:0] hb);
    @(posedge clk_i);
    write_cal(REG_CAL_TEMP, ct);
    write_cal(REG_CAL_PRESS_A, pa);
    write_cal(REG_CAL_PRESS_B, pb);
    write_cal(REG_CAL_PRESS_HUM, ph);
    write_cal(REG_CAL_HUM_B, hb);
    write_cal(REG_UNMAPPED, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    n_cal_sets++;
  endtask

  task automatic load_typical(bit zero_p1);
    logic [15:0] p1;
    p1 = zero_p1 ? 16'd0 : 16'd36477;
    load_cal_set(64'({16'hFC18, 16'd26435, 16'd27504}),
                 {16'd2855, 16'd3024, 16'hD643, p1},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 64'({8'd0, 16'd362, 8'd75, 16'd6000}),
                 64'({8'd30, 12'd50, 12'd324}));
  endtask

  task automatic send_raw(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    while (idle_on && ($urandom_range(99) < 33)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= t;
    raw_pressure_i <= p;
    raw_humidity_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    board.note_raw(t, p, h);
    n_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.expected_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic send_extremes;
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd0, 20'hFFFFF, 16'd0);
    send_raw(20'hFFFFF, 20'd0, 16'hFFFF);
  endtask

  task automatic random_burst(int n, bit realistic);
    for (int i = 0; i < n; i++) begin
      if (realistic && $urandom_range(9) < 8)
        send_raw(20'($urandom_range(600000, 400000)), 20'($urandom_range(500000, 200000)),
                 16'($urandom_range(50000, 20000)));
      else
        send_raw(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    raw_temperature_i = '0;
    raw_pressure_i = '0;
    raw_humidity_i = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    for (int i = 0; i < 5; i++) board.cal[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: divisor zero everywhere
    send_extremes();
    drain();

    load_typical(1'b0);
    send_extremes();
    send_raw(20'd519888, 20'd415148, 16'd29000);
    send_raw(20'd519888, 20'd415148, 16'hFFFF);
    send_raw(20'd300000, 20'd600000, 16'd100);
    drain();

    load_typical(1'b1);
    send_extremes();
    drain();

    load_cal_set('1, '1, '1, '1, '1);
    send_extremes();
    drain();
    load_cal_set(64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                 64'hFF7F_FFFF_7FFF, 64'h7F7F_F7FF);
    send_extremes();
    drain();
    load_cal_set(64'h8000_8000_0000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000,
                 64'h0080_0000_8000, 64'h8080_0800);
    send_extremes();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph != 2);
      if (ph[0]) begin
        load_typical(1'b0);
      end else begin
        load_cal_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      end
      if (ph == 3) hold_req = 1'b1;
      random_burst(150, ph[0]);
      drain();
    end

    $display("sent %0d transactions, checked %0d results over %0d calibration sets",
             n_sent, board.n_checked, n_cal_sets);
    $display("covered raw extremes, divisor zero, extreme and random calibration, stalls");
    if (board.n_errors == 0 && board.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/esc_pkg.sv
rtl/core/esc_sdiv.sv
rtl/core/env_sensor_compensation_top.sv
rtl/core/esc_checker.sv
test/env_sensor_compensation_top_test.sv
